### rtl/vna_pkg.sv
// vna_pkg: item types, mode codes and fixed-point constants for the
// vertex normal averager. No dependencies.
`timescale 1ns / 1ps
package vna_pkg;
	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_TRI   = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         vertex_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] start_nx;
		logic signed [15:0] start_ny;
		logic signed [15:0] start_nz;
		logic [7:0]         corner_a;
		logic [7:0]         corner_b;
		logic [7:0]         corner_c;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         out_index;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} out_item_t;

	localparam int ACC_W  = 24;
	localparam int MAG_W  = 40;
	localparam int NORM_W = 30;
	localparam int FIFO_DEPTH = 2;
endpackage

### rtl/vna_fifo.sv
// vna_fifo: small first-word-fall-through queue of input items.
// Depends on vna_pkg.
`timescale 1ns / 1ps
module vna_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  vna_pkg::in_item_t din,
	output logic              empty,
	input  logic              pop,
	output vna_pkg::in_item_t dout
);
	vna_pkg::in_item_t mem_q [vna_pkg::FIFO_DEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= din;
		end
	end
endmodule

### rtl/vna_unitize.sv
// vna_unitize: multicycle unit-length scaling of a signed 3-vector
// (normalize shift, bit-serial square root, restoring dividers). Depends on vna_pkg.
`timescale 1ns / 1ps
module vna_unitize #(
	parameter int FRAC = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [vna_pkg::MAG_W-1:0] vx,
	input  logic signed [vna_pkg::MAG_W-1:0] vy,
	input  logic signed [vna_pkg::MAG_W-1:0] vz,
	output logic                      done,
	output logic signed [FRAC+1:0]    nx,
	output logic signed [FRAC+1:0]    ny,
	output logic signed [FRAC+1:0]    nz
);
	localparam int MW = vna_pkg::MAG_W;
	localparam int NW = vna_pkg::NORM_W;
	localparam int DW = NW + FRAC + 1;
	typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_OUT} st_t;
	st_t st_q;
	logic [MW-1:0] m_q [3];
	logic neg_q [3];
	logic [63:0] sum_q, rem_q, root_q, bit_q;
	logic [1:0] sq_q, dv_q;
	logic [DW-1:0] num_q, dr_q;
	logic [5:0] cnt_q;
	logic [FRAC:0] q_q [3];
	logic [MW-1:0] mx;
	logic [NW-1:0] mt;
	logic [2*NW-1:0] prod;
	logic [DW:0] trial;

	assign mx = (m_q[0] | m_q[1] | m_q[2]);
	assign mt = m_q[sq_q][NW-1:0];
	assign prod = mt * mt;
	// partial remainder with the next dividend bit brought in
	assign trial = {num_q, rem_q[DW-1]} - {1'b0, dr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						m_q[0] <= vx[MW-1] ? MW'(-vx) : MW'(vx);
						m_q[1] <= vy[MW-1] ? MW'(-vy) : MW'(vy);
						m_q[2] <= vz[MW-1] ? MW'(-vz) : MW'(vz);
						neg_q[0] <= vx[MW-1];
						neg_q[1] <= vy[MW-1];
						neg_q[2] <= vz[MW-1];
						st_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// or of magnitudes shares the max's leading bit
					if (mx == '0) begin
						for (int i = 0; i < 3; i++) q_q[i] <= '0;
						st_q <= S_OUT;
					end else if (|mx[MW-1:NW]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					end else if (!mx[NW-1]) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						sum_q <= '0;
						sq_q <= 2'd0;
						st_q <= S_SQ;
					end
				end
				S_SQ: begin
					sum_q <= sum_q + 64'(prod);
					if (sq_q == 2'd2) begin
						st_q <= S_SQRT;
						root_q <= '0;
						bit_q <= 64'd1 << 62;
					end else begin
						sq_q <= sq_q + 2'd1;
					end
				end
				S_SQRT: begin
					if (bit_q == '0) begin
						dv_q <= 2'd0;
						num_q <= '0;
						cnt_q <= '0;
						dr_q <= DW'(root_q);
						st_q <= S_DIV;
					end else begin
						if (sum_q >= root_q + bit_q) begin
							sum_q <= sum_q - (root_q + bit_q);
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_DIV: begin
					// restoring divide: (m<<FRAC + len/2) / len, one bit a cycle
					if (cnt_q == 6'd0) begin
						rem_q <= 64'(({{(DW-NW){1'b0}}, m_q[dv_q][NW-1:0]} << FRAC)
							+ (dr_q >> 1));
						num_q <= '0;
						cnt_q <= 6'd1;
					end else begin
						if (trial[DW]) begin
							num_q <= {num_q[DW-2:0], rem_q[DW-1]};
						end else begin
							num_q <= trial[DW-1:0];
						end
						rem_q <= {rem_q[62:0], ~trial[DW]};
						if (cnt_q == 6'(DW)) begin
							q_q[dv_q] <= ({rem_q[DW-2:0], ~trial[DW]} > DW'(1 << FRAC))
								? (FRAC+1)'(1 << FRAC) : (FRAC+1)'({rem_q[DW-2:0], ~trial[DW]});
							cnt_q <= '0;
							if (dv_q == 2'd2) st_q <= S_OUT;
							else dv_q <= dv_q + 2'd1;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				S_OUT: begin
					nx <= neg_q[0] ? -$signed({1'b0, q_q[0]}) : $signed({1'b0, q_q[0]});
					ny <= neg_q[1] ? -$signed({1'b0, q_q[1]}) : $signed({1'b0, q_q[1]});
					nz <= neg_q[2] ? -$signed({1'b0, q_q[2]}) : $signed({1'b0, q_q[2]});
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/vna_core.sv
// vna_core: back end; position and accumulator memories, cross product,
// saturating updates and readout. Depends on vna_pkg and vna_unitize.
`timescale 1ns / 1ps
module vna_core #(
	parameter int MAX_VERTICES = 256,
	parameter int FRAC = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_take,
	input  vna_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output vna_pkg::out_item_t res
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int AC = vna_pkg::ACC_W;
	typedef enum logic [3:0] {C_IDLE, C_RDA, C_RDB, C_RDC, C_MUL, C_CRS,
		C_UNI, C_WAIT, C_RMW_RD, C_RMW_WR, C_ROUT} st_t;
	st_t st_q;
	logic [47:0] pos_mem [MAX_VERTICES];
	logic [3*AC-1:0] acc_mem [MAX_VERTICES];
	logic [47:0] pos_rd_q;
	logic [3*AC-1:0] acc_rd_q;
	logic [AW-1:0] pa, aa, ia_q, ib_q, ic_q;
	logic [1:0] k_q;
	logic [47:0] pa_q, pb_q;
	logic signed [16:0] e1 [3], e2 [3];
	logic signed [33:0] p_q [6];
	logic signed [vna_pkg::MAG_W-1:0] c_q [3];
	logic u_start, u_done, tri_q;
	logic signed [FRAC+1:0] nx, ny, nz;
	logic signed [FRAC+1:0] n_q [3];
	logic [7:0] idx_q;

	function automatic logic signed [AC-1:0] sat(input logic signed [AC-1:0] a,
		input logic signed [FRAC+1:0] b);
		logic signed [AC:0] s;
		s = {a[AC-1], a} + (AC+1)'(b);
		if (s[AC] != s[AC-1]) sat = s[AC] ? {1'b1, {(AC-1){1'b0}}} : {1'b0, {(AC-1){1'b1}}};
		else sat = s[AC-1:0];
	endfunction

	// index modulo MAX_VERTICES as a constant table over the 8-bit index
	function automatic logic [AW-1:0] wrap(input logic [7:0] v);
		wrap = '0;
		for (int i = 0; i < 256; i++) begin
			if (v == 8'(i)) wrap = AW'(i % MAX_VERTICES);
		end
	endfunction

	// a readout waits in the queue until the previous result is popped
	assign in_take = in_valid && (st_q == C_IDLE)
		&& (empty || item.mode != vna_pkg::MODE_READ);
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = $signed({pb_q[47-16*i], pb_q[47-16*i -: 16]})
				- $signed({pa_q[47-16*i], pa_q[47-16*i -: 16]});
			e2[i] = $signed({pos_rd_q[47-16*i], pos_rd_q[47-16*i -: 16]})
				- $signed({pa_q[47-16*i], pa_q[47-16*i -: 16]});
		end
		case (k_q)
			2'd0: aa = ia_q;
			2'd1: aa = ib_q;
			default: aa = ic_q;
		endcase
		case (st_q)
			C_RDA: pa = ia_q;
			C_RDB: pa = ib_q;
			C_RDC: pa = ic_q;
			default: pa = ia_q;
		endcase
	end
	assign u_start = (st_q == C_UNI);

	vna_unitize #(.FRAC(FRAC)) u_unit (
		.clk(clk), .arst_n(arst_n), .start(u_start),
		.vx(c_q[0]), .vy(c_q[1]), .vz(c_q[2]),
		.done(u_done), .nx(nx), .ny(ny), .nz(nz)
	);

	always_ff @(posedge clk) begin
		pos_rd_q <= pos_mem[pa];
		acc_rd_q <= acc_mem[(st_q == C_IDLE) ? wrap(item.vertex_index) : aa];
		if (in_take && item.mode == vna_pkg::MODE_LOAD) begin
			pos_mem[wrap(item.vertex_index)] <= {item.pos_x, item.pos_y, item.pos_z};
			acc_mem[wrap(item.vertex_index)] <= {AC'(item.start_nx), AC'(item.start_ny),
				AC'(item.start_nz)};
		end else if (st_q == C_RMW_WR) begin
			acc_mem[aa] <= {sat(acc_rd_q[3*AC-1 -: AC], n_q[0]),
				sat(acc_rd_q[2*AC-1 -: AC], n_q[1]), sat(acc_rd_q[AC-1:0], n_q[2])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			empty <= 1'b1;
		end else begin
			if (pop && !empty) empty <= 1'b1;
			case (st_q)
				C_IDLE: begin
					if (in_take) begin
						ia_q <= wrap(item.corner_a);
						ib_q <= wrap(item.corner_b);
						ic_q <= wrap(item.corner_c);
						idx_q <= item.vertex_index;
						k_q <= 2'd0;
						if (item.mode == vna_pkg::MODE_TRI) st_q <= C_RDA;
						else if (item.mode == vna_pkg::MODE_READ) st_q <= C_ROUT;
					end
				end
				C_RDA: st_q <= C_RDB;
				C_RDB: begin pa_q <= pos_rd_q; st_q <= C_RDC; end
				C_RDC: begin pb_q <= pos_rd_q; st_q <= C_MUL; end
				C_MUL: begin
					p_q[0] <= e1[1] * e2[2]; p_q[1] <= e1[2] * e2[1];
					p_q[2] <= e1[2] * e2[0]; p_q[3] <= e1[0] * e2[2];
					p_q[4] <= e1[0] * e2[1]; p_q[5] <= e1[1] * e2[0];
					st_q <= C_CRS;
				end
				C_CRS: begin
					for (int i = 0; i < 3; i++)
						c_q[i] <= vna_pkg::MAG_W'(p_q[2*i]) - vna_pkg::MAG_W'(p_q[2*i+1]);
					tri_q <= 1'b1;
					st_q <= C_UNI;
				end
				C_ROUT: begin
					for (int i = 0; i < 3; i++)
						c_q[i] <= vna_pkg::MAG_W'($signed(acc_rd_q[3*AC-1-AC*i -: AC]));
					tri_q <= 1'b0;
					st_q <= C_UNI;
				end
				C_UNI: st_q <= C_WAIT;
				C_WAIT: begin
					if (u_done) begin
						n_q[0] <= nx; n_q[1] <= ny; n_q[2] <= nz;
						if (tri_q) st_q <= C_RMW_RD;
						else begin
							res <= {idx_q, 16'(nx), 16'(ny), 16'(nz)};
							empty <= 1'b0;
							st_q <= C_IDLE;
						end
					end
				end
				C_RMW_RD: st_q <= C_RMW_WR;
				C_RMW_WR: begin
					if (k_q == 2'd2) st_q <= C_IDLE;
					else begin k_q <= k_q + 2'd1; st_q <= C_RMW_RD; end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule

### rtl/vertex_normal_averager.sv
// Vertex normal averager top: input queue in front of the back end. Depends on vna_pkg,
// vna_fifo, vna_core. One request at a time in the back end; a load is written as it is
// accepted and leaves the back end idle. The time of a triangle or a readout is set by the
// normalize shift, the bit-serial square root and the three divides; zero vectors finish
// early. A readout waits while the previous result is not popped.
// Reset (arst_n low) clears queue and control; the memories are not cleared.
`timescale 1ns / 1ps
module vertex_normal_averager #(
	parameter int MAX_VERTICES = 256,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  vna_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output vna_pkg::out_item_t out_item
);
	logic q_empty, q_take;
	vna_pkg::in_item_t q_item;

	vna_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(in_item),
		.empty(q_empty), .pop(q_take), .dout(q_item)
	);

	vna_core #(.MAX_VERTICES(MAX_VERTICES), .FRAC(NORMAL_FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .in_valid(!q_empty), .in_take(q_take),
		.item(q_item), .empty(empty), .pop(pop), .res(out_item)
	);
endmodule

### dv/tb.sv
// tb: self-checking bench for vertex_normal_averager; a scoreboard class predicts
// readout normals, a task drives the request queue and an always block pops results.
// Depends on vna_pkg and the RTL of vertex_normal_averager.
`timescale 1ns / 1ps
module tb;
	localparam int FRAC = 14;
	localparam int ACC_HI = 8388607;
	localparam int ACC_LO = -8388608;
	localparam int LIMIT = 3000000;
	localparam int N_RANDOM = 2000;

	class normal_tracker;
		int pos[256][3];
		int acc[256][3];
		vna_pkg::out_item_t due[$];
		int errors;

		function longint unsigned root64(longint unsigned s);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > s) b = b >> 2;
			while (b != 0) begin
				if (s >= r + b) begin
					s = s - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function void unit_scale(inout longint v0, inout longint v1, inout longint v2);
			longint unsigned m[3], mx, sum, len, q;
			bit neg[3];
			longint v[3];
			v[0] = v0; v[1] = v1; v[2] = v2;
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = v[i] < 0;
				m[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
				if (m[i] > mx) mx = m[i];
			end
			if (mx == 0) begin
				v0 = 0; v1 = 0; v2 = 0;
				return;
			end
			// common shift brings the largest magnitude into [2^29, 2^30)
			while (mx >= (64'd1 << 30)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			end
			while (mx < (64'd1 << 29)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			end
			sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			len = root64(sum);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << FRAC) + (len >> 1)) / len;
				if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
				v[i] = neg[i] ? -longint'(q) : longint'(q);
			end
			v0 = v[0]; v1 = v[1]; v2 = v[2];
		endfunction

		function int sat_sum(int a, longint b);
			longint s;
			s = longint'(a) + b;
			if (s > ACC_HI) s = ACC_HI;
			if (s < ACC_LO) s = ACC_LO;
			return int'(s);
		endfunction

		function void note(vna_pkg::in_item_t it);
			longint e1[3], e2[3], n0, n1, n2;
			int a, b, c, k;
			vna_pkg::out_item_t r;
			k = int'(it.vertex_index);
			case (vna_pkg::mode_t'(it.mode))
				vna_pkg::MODE_LOAD: begin
					pos[k][0] = int'(it.pos_x); pos[k][1] = int'(it.pos_y);
					pos[k][2] = int'(it.pos_z);
					acc[k][0] = int'(it.start_nx); acc[k][1] = int'(it.start_ny);
					acc[k][2] = int'(it.start_nz);
				end
				vna_pkg::MODE_TRI: begin
					a = int'(it.corner_a); b = int'(it.corner_b); c = int'(it.corner_c);
					for (int i = 0; i < 3; i++) begin
						e1[i] = longint'(pos[b][i]) - pos[a][i];
						e2[i] = longint'(pos[c][i]) - pos[a][i];
					end
					n0 = e1[1] * e2[2] - e1[2] * e2[1];
					n1 = e1[2] * e2[0] - e1[0] * e2[2];
					n2 = e1[0] * e2[1] - e1[1] * e2[0];
					unit_scale(n0, n1, n2);
					// corners in order; a repeated corner gets the add again
					for (int j = 0; j < 3; j++) begin
						k = (j == 0) ? a : (j == 1) ? b : c;
						acc[k][0] = sat_sum(acc[k][0], n0);
						acc[k][1] = sat_sum(acc[k][1], n1);
						acc[k][2] = sat_sum(acc[k][2], n2);
					end
				end
				vna_pkg::MODE_READ: begin
					n0 = acc[k][0]; n1 = acc[k][1]; n2 = acc[k][2];
					unit_scale(n0, n1, n2);
					r.out_index = it.vertex_index;
					r.normal_x = n0[15:0];
					r.normal_y = n1[15:0];
					r.normal_z = n2[15:0];
					due = {due, r};
				end
				default: ;
			endcase
		endfunction

		function void check(vna_pkg::out_item_t got);
			vna_pkg::out_item_t want;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = due.pop_front();
			if (got.out_index !== want.out_index || got.normal_x !== want.normal_x ||
			    got.normal_y !== want.normal_y || got.normal_z !== want.normal_z) begin
				errors++;
				if (errors <= 10)
					$display("mismatch idx exp %0d got %0d, n exp %0d %0d %0d got %0d %0d %0d",
						want.out_index, got.out_index, want.normal_x, want.normal_y,
						want.normal_z, got.normal_x, got.normal_y, got.normal_z);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	vna_pkg::in_item_t in_item = '0;
	vna_pkg::out_item_t out_item;

	normal_tracker sb = new;
	int cycles = 0;
	int rx_wait = 0;
	logic hold = 1'b0;
	bit loaded[256];
	int loaded_q[$];

	vertex_normal_averager dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: random pop gaps, calm stretches, and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			pop <= 1'b0;
			rx_wait <= 0;
		end else begin
			w = rx_wait;
			if (pop && !empty) begin
				sb.check(out_item);
				w = ((cycles / 700) % 2) ? 0 : $urandom_range(0, 6);
			end else if (w > 0) begin
				w = w - 1;
			end
			rx_wait <= w;
			pop <= (w == 0) && !hold;
		end
	end

	initial begin
		@(posedge arst_n);
		repeat (3000) @(posedge clk);
		hold <= 1'b1;
		repeat (4000) @(posedge clk);
		hold <= 1'b0;
	end

	task automatic send(vna_pkg::in_item_t it, int gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		sb.note(it);
		if (it.mode == vna_pkg::MODE_LOAD && !loaded[it.vertex_index]) begin
			loaded[it.vertex_index] = 1'b1;
			loaded_q = {loaded_q, int'(it.vertex_index)};
		end
	endtask

	function automatic vna_pkg::in_item_t noise();
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[$bits(vna_pkg::in_item_t)-1:0];
	endfunction

	function automatic logic [15:0] rand_norm();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic logic [15:0] rand_pos();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic vna_pkg::in_item_t mk_load(int k, logic [15:0] x, logic [15:0] y,
	                                     logic [15:0] z, logic [15:0] nx, logic [15:0] ny,
	                                     logic [15:0] nz);
		vna_pkg::in_item_t it;
		it = noise();
		it.mode = vna_pkg::MODE_LOAD; it.vertex_index = 8'(k);
		it.pos_x = x; it.pos_y = y; it.pos_z = z;
		it.start_nx = nx; it.start_ny = ny; it.start_nz = nz;
		return it;
	endfunction

	function automatic vna_pkg::in_item_t mk_tri(int a, int b, int c);
		vna_pkg::in_item_t it;
		it = noise();
		it.mode = vna_pkg::MODE_TRI;
		it.corner_a = 8'(a); it.corner_b = 8'(b); it.corner_c = 8'(c);
		return it;
	endfunction

	function automatic vna_pkg::in_item_t mk_read(int k);
		vna_pkg::in_item_t it;
		it = noise();
		it.mode = vna_pkg::MODE_READ; it.vertex_index = 8'(k);
		return it;
	endfunction

	function automatic int pick_loaded();
		return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
	endfunction

	initial begin
		vna_pkg::in_item_t it;
		int g;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme positions and normals, degenerate and zero cases
		send(mk_load(0, 16'h8000, 16'h8000, 16'h8000, 16'sd16384, 16'd0, 16'd0), 0);
		send(mk_load(1, 16'h7fff, 16'h8000, 16'h7fff, -16'sd16384, -16'sd16384, 16'd0), 0);
		send(mk_load(2, 16'h8000, 16'h7fff, 16'h7fff, 16'd0, 16'd0, -16'sd16384), 0);
		send(mk_load(3, 16'h7fff, 16'h7fff, 16'h7fff, 16'sd16384, 16'sd16384,
			16'sd16384), 0);
		send(mk_load(255, 16'h0100, 16'h0000, 16'hff00, 16'd0, 16'sd1, 16'd0), 0);
		send(mk_load(4, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
		send(mk_read(4), 0);
		send(mk_tri(0, 1, 2), 0);
		send(mk_tri(0, 0, 1), 0);
		send(mk_tri(1, 2, 3), 0);
		send(mk_tri(3, 3, 3), 0);
		send(mk_tri(255, 0, 255), 0);
		it = noise(); it.mode = vna_pkg::MODE_NONE;
		send(it, 0);
		for (int k = 0; k < 5; k++) send(mk_read(k), 0);
		send(mk_read(255), 0);

		for (int n = 0; n < N_RANDOM; n++) begin
			int r, a;
			g = ((n / 300) % 2) ? 0 : $urandom_range(0, 6);
			r = $urandom_range(0, 99);
			if (r < 25) begin
				a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
				it = mk_load(a, rand_pos(), rand_pos(), rand_pos(), rand_norm(), rand_norm(),
					rand_norm());
			end else if (r < 65) begin
				if ($urandom_range(0, 9) == 0) begin
					a = pick_loaded();
					it = mk_tri(a, pick_loaded(), a);
				end else begin
					it = mk_tri(pick_loaded(), pick_loaded(), pick_loaded());
				end
			end else if (r < 95) begin
				it = mk_read(pick_loaded());
			end else begin
				it = noise(); it.mode = vna_pkg::MODE_NONE;
			end
			send(it, g);
		end
		push <= 1'b0;

		while (sb.due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

### sim.f
rtl/vna_pkg.sv
rtl/vna_fifo.sv
rtl/vna_unitize.sv
rtl/vna_core.sv
rtl/vertex_normal_averager.sv
dv/tb.sv
